// ----- src/tccw_pkg.sv -----
package tccw_pkg;

    localparam int SCREEN_ROWS_DEF = 25;
    localparam int SCREEN_COLS_DEF = 80;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0] RESET_ATTR  = 8'h1F;
    localparam logic [7:0] BLANK_GLYPH = 8'h20;
    localparam logic [7:0] GLYPH_LF    = 8'h0A;
    localparam logic [7:0] GLYPH_CR    = 8'h0D;

    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_FILL   = 3'd3;
    localparam logic [2:0] OP_SETCUR = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    typedef enum logic [3:0] {
        ST_INIT_SETUP,
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL_COPY,
        ST_SCROLL_SETUP,
        ST_SCROLL_BLANK,
        ST_PUT_WRITE,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        SWP_INIT,
        SWP_CLEAR,
        SWP_COPY,
        SWP_LAST,
        SWP_FILL
    } sweep_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_PUT,
        WR_AT
    } wr_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_NEWLINE,
        CUR_CR,
        CUR_ADVANCE,
        CUR_SET,
        CUR_HOME,
        CUR_LAST_ROW
    } cur_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     sweep_start;
        sweep_t   sweep_kind;
        logic     sweep_step;
        wr_sel_t  wr_sel;
        logic     read_at;
        cur_sel_t cur_sel;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       is_lf;
        logic       is_cr;
        logic       row_pending;
        logic       on_screen;
        logic       fill_empty;
        logic       sweep_last;
        logic       copy_wr;
        logic       out_free;
    } dp_status_t;

endpackage

// ----- src/text_console_cell_writer.sv -----
// Put char without scroll, write, read, set cursor: accept in idle, execute, load
// the result when the output slot is free, one word in flight. Fill adds a sweep of
// the clipped w*h cells, clear one of every cell, scroll a copy then a last-row blank.
// The single write port of the cell store sets the sweep lengths, one cell per cycle.
// Reset (aresetn low, synchronous): cursor 0,0, attribute 0x1F, then a clearing pass
// over all ROWS*COLS cells with s_tready low; config writes are taken.
module text_console_cell_writer #(
    parameter int SCREEN_ROWS = tccw_pkg::SCREEN_ROWS_DEF,
    parameter int SCREEN_COLS = tccw_pkg::SCREEN_COLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // glyph[7:0], cell_attr[15:8], pos_x[22:16], pos_y[27:23],
    // rect_width[34:28], rect_height[39:35]
    input  logic [tccw_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[2:0]
    input  logic [tccw_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_value[15:0], cursor_row[20:16], cursor_col[27:21], zero[31:28]
    output logic [tccw_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [7:0]                      cfg_data
);
    import tccw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tccw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tccw_dp #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // one word in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // result only loaded into a free output slot
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending word");

    // delayed scroll-copy write owns the write port
    a_wr_port: assert property (@(posedge aclk) disable iff (!aresetn)
        status.copy_wr |-> (cmd.wr_sel == WR_NONE))
        else $error("write port conflict with scroll copy");

endmodule

// ----- src/tccw_ctrl.sv -----
module tccw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tccw_pkg::dp_status_t status,
    output tccw_pkg::ctrl_cmd_t  cmd
);
    import tccw_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_SETUP;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT_SETUP: state_next = ST_INIT;
            ST_INIT: begin
                if (status.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (status.opcode)
                    OP_PUT: begin
                        if (!status.is_lf && !status.is_cr && status.row_pending) begin
                            state_next = ST_SCROLL_COPY;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_FILL:  state_next = status.fill_empty ? ST_DONE : ST_FILL;
                    OP_CLEAR: state_next = ST_CLEAR;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_SCROLL_COPY: begin
                if (status.sweep_last) state_next = ST_SCROLL_SETUP;
            end
            ST_SCROLL_SETUP: state_next = ST_SCROLL_BLANK;
            ST_SCROLL_BLANK: begin
                if (status.sweep_last) state_next = ST_PUT_WRITE;
            end
            ST_PUT_WRITE: state_next = ST_DONE;
            ST_FILL, ST_CLEAR: begin
                if (status.sweep_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT_SETUP;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.sweep_kind  = SWP_INIT;
        cmd.wr_sel      = WR_NONE;
        cmd.cur_sel     = CUR_HOLD;
        s_tready        = 1'b0;
        unique case (state_reg)
            ST_INIT_SETUP: begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_kind  = SWP_INIT;
            end
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_EXEC: begin
                unique case (status.opcode)
                    OP_PUT: begin
                        priority if (status.is_lf) begin
                            cmd.cur_sel = CUR_NEWLINE;
                        end else if (status.is_cr) begin
                            cmd.cur_sel = CUR_CR;
                        end else if (status.row_pending) begin
                            cmd.sweep_start = 1'b1;
                            cmd.sweep_kind  = SWP_COPY;
                        end else begin
                            cmd.wr_sel  = WR_PUT;
                            cmd.cur_sel = CUR_ADVANCE;
                        end
                    end
                    OP_WRITE: begin
                        if (status.on_screen) cmd.wr_sel = WR_AT;
                    end
                    OP_READ:  cmd.read_at = status.on_screen;
                    OP_FILL: begin
                        cmd.sweep_start = !status.fill_empty;
                        cmd.sweep_kind  = SWP_FILL;
                    end
                    OP_SETCUR: cmd.cur_sel = CUR_SET;
                    OP_CLEAR: begin
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_kind  = SWP_CLEAR;
                        cmd.cur_sel     = CUR_HOME;
                    end
                    default: ;
                endcase
            end
            ST_SCROLL_SETUP: begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_kind  = SWP_LAST;
            end
            ST_SCROLL_BLANK: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) cmd.cur_sel = CUR_LAST_ROW;
            end
            ST_PUT_WRITE: begin
                cmd.wr_sel  = WR_PUT;
                cmd.cur_sel = CUR_ADVANCE;
            end
            ST_INIT, ST_SCROLL_COPY, ST_FILL, ST_CLEAR: cmd.sweep_step = 1'b1;
            ST_DONE: cmd.out_load = status.out_free;
            default: ;
        endcase
    end

endmodule

// ----- src/tccw_dp.sv -----
module tccw_dp #(
    parameter int SCREEN_ROWS = tccw_pkg::SCREEN_ROWS_DEF,
    parameter int SCREEN_COLS = tccw_pkg::SCREEN_COLS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [tccw_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [tccw_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             cfg_we,
    input  logic [7:0]                       cfg_data,
    input  tccw_pkg::ctrl_cmd_t              cmd,
    output tccw_pkg::dp_status_t             status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tccw_pkg::M_TDATA_W-1:0]   m_tdata
);
    import tccw_pkg::*;

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(SCREEN_ROWS + 1);  // cursor row, holds SCREEN_ROWS
    localparam int RAW   = $clog2(SCREEN_ROWS);      // cell row index
    localparam int CW    = $clog2(SCREEN_COLS);
    localparam logic [AW-1:0] COLS_A = AW'(SCREEN_COLS);
    localparam logic [7:0]    COLS8  = 8'(SCREEN_COLS);
    localparam logic [6:0]    ROWS7  = 7'(SCREEN_ROWS);

    function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
        return r * COLS_A + c;
    endfunction

    // item registers
    logic [2:0]  op_reg;
    logic [7:0]  glyph_reg, cattr_reg;
    logic [6:0]  px_reg, rw_reg;
    logic [4:0]  py_reg, rh_reg;
    logic [7:0]  text_attr_reg;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;

    // sweep engine
    sweep_t         kind_reg;
    logic [RAW-1:0] sw_row_reg, row_last_reg;
    logic [CW-1:0]  sw_col_reg, col_first_reg, col_last_reg;

    logic [15:0]   mem [CELLS];
    logic [15:0]   rdata_reg;
    logic          cp_valid_reg;
    logic [AW-1:0] cp_addr_reg;

    logic          m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= s_tuser;
            glyph_reg <= s_tdata[7:0];
            cattr_reg <= s_tdata[15:8];
            px_reg    <= s_tdata[22:16];
            py_reg    <= s_tdata[27:23];
            rw_reg    <= s_tdata[34:28];
            rh_reg    <= s_tdata[39:35];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attr_reg <= RESET_ATTR;
        end else if (cfg_we) begin
            text_attr_reg <= cfg_data;
        end
    end

    logic on_screen, fill_empty, row_pending;
    logic [7:0] fill_col_end, fill_col_clip;
    logic [6:0] fill_row_end, fill_row_clip;

    assign on_screen    = ({1'b0, px_reg} < COLS8) && ({2'b0, py_reg} < ROWS7);
    assign fill_empty   = !on_screen || (rw_reg == 7'd0) || (rh_reg == 5'd0);
    assign row_pending  = cur_row_reg == RW'(SCREEN_ROWS);
    assign fill_col_end = {1'b0, px_reg} + {1'b0, rw_reg};
    assign fill_row_end = {2'b0, py_reg} + {2'b0, rh_reg};
    assign fill_col_clip = (fill_col_end > COLS8) ? COLS8 : fill_col_end;
    assign fill_row_clip = (fill_row_end > ROWS7) ? ROWS7 : fill_row_end;

    always_comb begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        unique case (cmd.cur_sel)
            CUR_HOLD: ;
            CUR_NEWLINE: begin
                if (!row_pending) cur_row_next = cur_row_reg + RW'(1);
                cur_col_next = '0;
            end
            CUR_CR: cur_col_next = '0;
            CUR_ADVANCE: begin
                if (cur_col_reg == CW'(SCREEN_COLS - 1)) begin
                    cur_col_next = '0;
                    cur_row_next = cur_row_reg + RW'(1);
                end else begin
                    cur_col_next = cur_col_reg + CW'(1);
                end
            end
            CUR_SET: begin
                cur_col_next = ({1'b0, px_reg} < COLS8) ? CW'(px_reg) : CW'(SCREEN_COLS - 1);
                cur_row_next = ({2'b0, py_reg} < ROWS7) ? RW'(py_reg) : RW'(SCREEN_ROWS);
            end
            CUR_HOME: begin
                cur_row_next = '0;
                cur_col_next = '0;
            end
            CUR_LAST_ROW: begin
                cur_row_next = RW'(SCREEN_ROWS - 1);
                cur_col_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end else begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
        end
    end

    logic sweep_last;
    assign sweep_last = (sw_col_reg == col_last_reg) && (sw_row_reg == row_last_reg);

    always_ff @(posedge aclk) begin
        if (cmd.sweep_start) begin
            kind_reg <= cmd.sweep_kind;
            unique case (cmd.sweep_kind)
                SWP_INIT, SWP_CLEAR: begin
                    sw_row_reg    <= '0;
                    row_last_reg  <= RAW'(SCREEN_ROWS - 1);
                    sw_col_reg    <= '0;
                    col_first_reg <= '0;
                    col_last_reg  <= CW'(SCREEN_COLS - 1);
                end
                SWP_COPY: begin
                    sw_row_reg    <= '0;
                    row_last_reg  <= RAW'(SCREEN_ROWS - 2);
                    sw_col_reg    <= '0;
                    col_first_reg <= '0;
                    col_last_reg  <= CW'(SCREEN_COLS - 1);
                end
                SWP_LAST: begin
                    sw_row_reg    <= RAW'(SCREEN_ROWS - 1);
                    row_last_reg  <= RAW'(SCREEN_ROWS - 1);
                    sw_col_reg    <= '0;
                    col_first_reg <= '0;
                    col_last_reg  <= CW'(SCREEN_COLS - 1);
                end
                SWP_FILL: begin
                    sw_row_reg    <= RAW'(py_reg);
                    row_last_reg  <= RAW'(fill_row_clip - 7'd1);
                    sw_col_reg    <= CW'(px_reg);
                    col_first_reg <= CW'(px_reg);
                    col_last_reg  <= CW'(fill_col_clip - 8'd1);
                end
                default: ;
            endcase
        end else if (cmd.sweep_step) begin
            if (sw_col_reg == col_last_reg) begin
                sw_col_reg <= col_first_reg;
                sw_row_reg <= sw_row_reg + RAW'(1);
            end else begin
                sw_col_reg <= sw_col_reg + CW'(1);
            end
        end
    end

    // memory ports
    logic          we, re, copy_step;
    logic [AW-1:0] waddr, raddr, sweep_addr;
    logic [15:0]   wdata;

    assign copy_step  = cmd.sweep_step && (kind_reg == SWP_COPY);
    assign sweep_addr = cell_addr(AW'(sw_row_reg), AW'(sw_col_reg));

    always_comb begin
        we    = 1'b0;
        waddr = sweep_addr;
        wdata = {text_attr_reg, BLANK_GLYPH};
        priority if (cp_valid_reg) begin
            // delayed half of a scroll copy
            we    = 1'b1;
            waddr = cp_addr_reg;
            wdata = rdata_reg;
        end else if (cmd.sweep_step && !copy_step) begin
            we = 1'b1;
            unique case (kind_reg)
                SWP_INIT: wdata = {RESET_ATTR, BLANK_GLYPH};
                SWP_FILL: wdata = {cattr_reg, glyph_reg};
                default:  wdata = {text_attr_reg, BLANK_GLYPH};
            endcase
        end else if (cmd.wr_sel == WR_PUT) begin
            we    = 1'b1;
            waddr = cell_addr(AW'(cur_row_reg), AW'(cur_col_reg));
            wdata = {text_attr_reg, glyph_reg};
        end else if (cmd.wr_sel == WR_AT) begin
            we    = 1'b1;
            waddr = cell_addr(AW'(py_reg), AW'(px_reg));
            wdata = {cattr_reg, glyph_reg};
        end
    end

    assign re    = copy_step || cmd.read_at;
    assign raddr = copy_step ? cell_addr(AW'(sw_row_reg) + AW'(1), AW'(sw_col_reg))
                             : cell_addr(AW'(py_reg), AW'(px_reg));

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cp_valid_reg <= 1'b0;
        end else begin
            cp_valid_reg <= copy_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (copy_step) cp_addr_reg <= sweep_addr;
    end

    // result register
    logic [31:0] row_wide, col_wide;
    logic [15:0] value;
    assign row_wide = 32'(cur_row_reg);
    assign col_wide = 32'(cur_col_reg);
    assign value    = (op_reg == OP_READ && on_screen) ? rdata_reg : 16'h0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {4'b0, col_wide[6:0], row_wide[4:0], value};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign status.opcode      = op_reg;
    assign status.is_lf       = glyph_reg == GLYPH_LF;
    assign status.is_cr       = glyph_reg == GLYPH_CR;
    assign status.row_pending = row_pending;
    assign status.on_screen   = on_screen;
    assign status.fill_empty  = fill_empty;
    assign status.sweep_last  = sweep_last;
    assign status.copy_wr     = cp_valid_reg;
    assign status.out_free    = !m_valid_reg || m_tready;

endmodule

// ----- dv/text_console_cell_writer_test.sv -----
module text_console_cell_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    localparam int ROWS  = SCREEN_ROWS_DEF;
    localparam int COLS  = SCREEN_COLS_DEF;
    localparam int CELLS = ROWS * COLS;

    // opcodes the block must treat as no-ops
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int RANDOM_WORDS  = 600;
    localparam int RANDOM_PHASES = 5;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] glyph;
        logic [7:0] cell_attr;
        logic [6:0] pos_x;
        logic [4:0] pos_y;
        logic [6:0] rect_width;
        logic [4:0] rect_height;
    } console_op_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } console_res_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [7:0]           cfg_data = '0;

    // screen image and cursor as the block should hold them
    logic [15:0]  shadow_cells [CELLS];
    int           shadow_row;
    int           shadow_col;
    logic [7:0]   shadow_attr;
    console_res_t pending_results [$];

    bit gaps_on = 1'b1;
    int rx_hold = 0;
    int fail_count = 0;
    int results_seen = 0;
    int scroll_count = 0;
    int attr_writes = 0;
    int cycle_count = 0;
    int op_count [8];

    text_console_cell_writer #(
        .SCREEN_ROWS(ROWS),
        .SCREEN_COLS(COLS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_console_cell_writer_test: FAIL");
            $finish;
        end
    end

    function automatic void blank_cells(input int from, input int upto, input logic [7:0] attr);
        for (int i = from; i < upto; i++)
            shadow_cells[i] = {attr, BLANK_GLYPH};
    endfunction

    function automatic console_res_t apply_console_op(input console_op_t w);
        console_res_t res;
        bit           on_screen;
        int           x;
        int           y;
        x = int'(w.pos_x);
        y = int'(w.pos_y);
        on_screen = (x < COLS) && (y < ROWS);
        res = '0;
        case (w.opcode)
            OP_PUT: begin
                if (w.glyph == GLYPH_LF) begin
                    if (shadow_row < ROWS)
                        shadow_row++;
                    shadow_col = 0;
                end else if (w.glyph == GLYPH_CR) begin
                    shadow_col = 0;
                end else begin
                    if (shadow_row >= ROWS) begin
                        for (int i = 0; i < (ROWS - 1) * COLS; i++)
                            shadow_cells[i] = shadow_cells[i + COLS];
                        blank_cells((ROWS - 1) * COLS, CELLS, shadow_attr);
                        shadow_row = ROWS - 1;
                        shadow_col = 0;
                        scroll_count++;
                    end
                    shadow_cells[shadow_row * COLS + shadow_col] = {shadow_attr, w.glyph};
                    shadow_col++;
                    if (shadow_col >= COLS) begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                end
            end
            OP_WRITE: begin
                if (on_screen)
                    shadow_cells[y * COLS + x] = {w.cell_attr, w.glyph};
            end
            OP_READ: begin
                if (on_screen)
                    res.cell_value = shadow_cells[y * COLS + x];
            end
            OP_FILL: begin
                // clipped at right and bottom edges
                for (int r = y; r < y + int'(w.rect_height) && r < ROWS; r++)
                    for (int c = x; c < x + int'(w.rect_width) && c < COLS; c++)
                        shadow_cells[r * COLS + c] = {w.cell_attr, w.glyph};
            end
            OP_SETCUR: begin
                shadow_col = (x < COLS) ? x : COLS - 1;
                shadow_row = (y < ROWS) ? y : ROWS;
            end
            OP_CLEAR: begin
                blank_cells(0, CELLS, shadow_attr);
                shadow_row = 0;
                shadow_col = 0;
            end
            default: ;
        endcase
        res.cursor_row = shadow_row[4:0];
        res.cursor_col = shadow_col[6:0];
        return res;
    endfunction

    function automatic console_op_t make_op(input logic [2:0] opcode, input logic [7:0] glyph,
                                            input logic [7:0] attr, input logic [6:0] x,
                                            input logic [4:0] y, input logic [6:0] w,
                                            input logic [4:0] h);
        console_op_t op;
        op.opcode      = opcode;
        op.glyph       = glyph;
        op.cell_attr   = attr;
        op.pos_x       = x;
        op.pos_y       = y;
        op.rect_width  = w;
        op.rect_height = h;
        return op;
    endfunction

    function automatic console_op_t random_op();
        console_op_t w;
        int          pick;
        int          near_row;
        w.glyph       = 8'($urandom_range(0, 255));
        w.cell_attr   = 8'($urandom_range(0, 255));
        w.pos_x       = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(0, COLS - 1));
        w.pos_y       = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, ROWS - 1));
        w.rect_width  = 7'($urandom_range(0, 8));
        w.rect_height = 5'($urandom_range(0, 4));
        pick = $urandom_range(0, 199);
        if (pick < 80) begin
            w.opcode = OP_PUT;
            case ($urandom_range(0, 19))
                0, 1:    w.glyph = GLYPH_LF;
                2:       w.glyph = GLYPH_CR;
                default: ;
            endcase
        end else if (pick < 110) begin
            w.opcode = OP_WRITE;
        end else if (pick < 145) begin
            w.opcode = OP_READ;
            // half the reads look just behind the cursor where text lands
            if ($urandom_range(0, 1)) begin
                near_row = (shadow_row >= ROWS) ? ROWS - 1 : shadow_row;
                w.pos_y = 5'(near_row - $urandom_range(0, (near_row < 2) ? near_row : 2));
                w.pos_x = 7'(shadow_col - $urandom_range(0, (shadow_col < 8) ? shadow_col : 8));
            end
        end else if (pick < 165) begin
            w.opcode = OP_FILL;
            if ($urandom_range(0, 9) == 0) begin
                w.rect_width  = 7'($urandom_range(0, 127));
                w.rect_height = 5'($urandom_range(0, 31));
            end
        end else if (pick < 185) begin
            w.opcode = OP_SETCUR;
            // park near or past the bottom so text provokes scrolling
            if ($urandom_range(0, 2) == 0)
                w.pos_y = 5'($urandom_range(ROWS - 2, 31));
        end else if (pick < 189) begin
            w.opcode = OP_CLEAR;
        end else begin
            w.opcode = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        return w;
    endfunction

    task automatic send_op(input console_op_t w);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.rect_height, w.rect_width, w.pos_y, w.pos_x, w.cell_attr, w.glyph};
        s_tuser  <= w.opcode;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_console_op(w));
        op_count[w.opcode]++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_text_attr(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_attr = value;
        attr_writes++;
    endtask

    task automatic test_directed_edges();
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_PUT, 8'h41, 8'h00, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_WRITE, 8'hFF, 8'hFF, 7'd79, 5'd24, 7'd0, 5'd0));
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd79, 5'd24, 7'd0, 5'd0));
        // off-screen writes are dropped, off-screen reads return zero
        send_op(make_op(OP_WRITE, 8'h00, 8'h00, 7'd80, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_WRITE, 8'h00, 8'h00, 7'd0, 5'd25, 7'd0, 5'd0));
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd127, 5'd31, 7'd0, 5'd0));
        // cursor saturates to last column and the scroll-pending row
        send_op(make_op(OP_SETCUR, 8'h00, 8'h00, 7'd127, 5'd31, 7'd0, 5'd0));
        send_op(make_op(OP_PUT, GLYPH_LF, 8'h00, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_PUT, GLYPH_CR, 8'h00, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_PUT, 8'h00, 8'h00, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd79, 5'd23, 7'd0, 5'd0));
        // wrap from the last column
        send_op(make_op(OP_SETCUR, 8'h00, 8'h00, 7'd79, 5'd3, 7'd0, 5'd0));
        send_op(make_op(OP_PUT, 8'h7E, 8'h00, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_FILL, 8'hAA, 8'h55, 7'd70, 5'd20, 7'd127, 5'd31));
        send_op(make_op(OP_FILL, 8'hFF, 8'hFF, 7'd0, 5'd0, 7'd0, 5'd5));
        send_op(make_op(OP_FILL, 8'hFF, 8'hFF, 7'd0, 5'd0, 7'd5, 5'd0));
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd79, 5'd24, 7'd0, 5'd0));
        send_op(make_op(OP_SPARE_6, 8'h00, 8'h00, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_SPARE_7, 8'hFF, 8'hFF, 7'h7F, 5'h1F, 7'h7F, 5'h1F));
        send_op(make_op(OP_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd40, 5'd12, 7'd0, 5'd0));
        wait_idle();
    endtask

    task automatic test_text_attr();
        write_text_attr(8'h00);
        send_op(make_op(OP_PUT, 8'h78, 8'hFF, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_CLEAR, 8'h00, 8'hFF, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd3, 5'd3, 7'd0, 5'd0));
        send_op(make_op(OP_PUT, 8'h61, 8'hFF, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0, 7'd0, 5'd0));
        wait_idle();
        // scroll blanks the new bottom row with the current attribute
        write_text_attr(8'hFF);
        send_op(make_op(OP_SETCUR, 8'h00, 8'h00, 7'd10, 5'd25, 7'd0, 5'd0));
        send_op(make_op(OP_PUT, 8'h7A, 8'h00, 7'd0, 5'd0, 7'd0, 5'd0));
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd5, 5'd24, 7'd0, 5'd0));
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd0, 5'd24, 7'd0, 5'd0));
        send_op(make_op(OP_READ, 8'h00, 8'h00, 7'd0, 5'd23, 7'd0, 5'd0));
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        // receiver holds off while words keep coming, so s_tready must drop
        rx_hold = 120;
        repeat (16) send_op(random_op());
        wait_idle();
    endtask

    task automatic test_random_traffic();
        console_op_t w;
        int          sent;
        int          run_len;
        logic [7:0]  phase_attrs [RANDOM_PHASES];
        phase_attrs = '{8'h1F, 8'h70, 8'h00, 8'h00, 8'hFF};
        phase_attrs[3] = 8'($urandom_range(0, 255));
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            write_text_attr(phase_attrs[phase]);
            if (phase == RANDOM_PHASES - 1)
                gaps_on = 1'b0;
            sent = 0;
            while (sent < RANDOM_WORDS / RANDOM_PHASES) begin
                if ($urandom_range(0, 3) == 0) begin
                    // a line of printable text, often terminated
                    run_len = $urandom_range(4, 24);
                    repeat (run_len) begin
                        w = random_op();
                        w.opcode = OP_PUT;
                        w.glyph  = 8'($urandom_range(8'h20, 8'h7E));
                        send_op(w);
                    end
                    sent += run_len;
                    if ($urandom_range(0, 1)) begin
                        w = random_op();
                        w.opcode = OP_PUT;
                        w.glyph  = GLYPH_LF;
                        send_op(w);
                        sent++;
                    end
                end else begin
                    send_op(random_op());
                    sent++;
                end
            end
        end
        wait_idle();
    endtask

    initial begin : result_check
        console_res_t got;
        console_res_t want;
        int           stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.cell_value = m_tdata[15:0];
                got.cursor_row = m_tdata[20:16];
                got.cursor_col = m_tdata[27:21];
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result word %h with nothing expected", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.cell_value !== want.cell_value) begin
                        $error("cell_value: expected %h, got %h", want.cell_value, got.cell_value);
                        fail_count++;
                    end
                    if (got.cursor_row !== want.cursor_row) begin
                        $error("cursor_row: expected %0d, got %0d", want.cursor_row,
                               got.cursor_row);
                        fail_count++;
                    end
                    if (got.cursor_col !== want.cursor_col) begin
                        $error("cursor_col: expected %0d, got %0d", want.cursor_col,
                               got.cursor_col);
                        fail_count++;
                    end
                end
            end
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        blank_cells(0, CELLS, RESET_ATTR);
        shadow_row  = 0;
        shadow_col  = 0;
        shadow_attr = RESET_ATTR;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_edges();
        test_text_attr();
        test_output_backpressure();
        test_random_traffic();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        $display("sent put %0d, write %0d, read %0d, fill %0d, cursor %0d, clear %0d, spare %0d",
                 op_count[OP_PUT], op_count[OP_WRITE], op_count[OP_READ], op_count[OP_FILL],
                 op_count[OP_SETCUR], op_count[OP_CLEAR],
                 op_count[OP_SPARE_6] + op_count[OP_SPARE_7]);
        $display("%0d results checked, %0d scrolls, %0d attribute writes, %0d errors",
                 results_seen, scroll_count, attr_writes, fail_count);
        if (fail_count == 0) begin
            $display("text_console_cell_writer_test: PASS");
        end else begin
            $display("text_console_cell_writer_test: FAIL");
        end
        $finish;
    end

endmodule
